// ===== rtl/core/qta_pkg.sv =====
// Shared types, stage counts and angle constants of the quaternion to axis-angle pipeline.
package qta_pkg;

    localparam int SQRT_STEPS   = 24;
    localparam int CORDIC_STEPS = 16;
    localparam int DIV_BITS     = 17;
    localparam int RAD_W        = 48;
    localparam int ROOT_W       = 24;
    localparam int XW           = 27;
    localparam int ZW           = 26;
    // Multiply stage, square-root steps, CORDIC set-up, rotations and clamp.
    localparam int PIPE_DEPTH   = 1 + SQRT_STEPS + 1 + CORDIC_STEPS + 1;

    localparam logic signed [ZW-1:0] HALF_TURN_Q16    = 26'sd11796480;
    localparam logic signed [ZW-1:0] QUARTER_TURN_Q16 = 26'sd5898240;

    typedef logic signed [ZW-1:0] angle_acc_t;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } qta_quat_t;

    typedef struct packed {
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic [15:0]        angle_deg;
    } qta_result_t;

    // atan(2^-i) in degrees, scaled by 2^16 and rounded.
    function automatic angle_acc_t atan_deg(input logic [3:0] idx);
        angle_acc_t r;
        case (idx)
            4'd0:    r = 26'sd2949120;
            4'd1:    r = 26'sd1740967;
            4'd2:    r = 26'sd919879;
            4'd3:    r = 26'sd466945;
            4'd4:    r = 26'sd234379;
            4'd5:    r = 26'sd117304;
            4'd6:    r = 26'sd58666;
            4'd7:    r = 26'sd29335;
            4'd8:    r = 26'sd14668;
            4'd9:    r = 26'sd7334;
            4'd10:   r = 26'sd3667;
            4'd11:   r = 26'sd1833;
            4'd12:   r = 26'sd917;
            4'd13:   r = 26'sd458;
            4'd14:   r = 26'sd229;
            default: r = 26'sd115;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/quaternion_to_axis_angle.sv =====
// Top level of the quaternion to axis-angle converter: pipeline control and output queue.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+----------------------------------------------
//  s_      | in        | s_valid / s_ready  | s_quat_w, s_quat_x, s_quat_y, s_quat_z
//  m_      | out       | m_valid / m_ready  | m_axis_x, m_axis_y, m_axis_z, m_angle_deg
//
// One transaction is taken in every cycle while the pipeline is not halted. Each one passes
// one multiply stage, 24 square-root stages (one root bit each) and 18 stages in which the
// CORDIC and the three dividers run side by side, the dividers' 17 quotient bits setting that
// length. Results then wait in a two-entry output queue, whose head drives m_valid. Reset
// clears the valid bits of every stage and empties the queue. The whole pipeline halts only
// when the queue is full and m_ready is low, so nothing is lost or repeated.
module quaternion_to_axis_angle
    import qta_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_quat_w,
    input  logic signed [15:0] s_quat_x,
    input  logic signed [15:0] s_quat_y,
    input  logic signed [15:0] s_quat_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_axis_x,
    output logic signed [15:0] m_axis_y,
    output logic signed [15:0] m_axis_z,
    output logic [15:0]        m_angle_deg
);

    // Pipeline advance. The queue can always take a result unless it is full and not draining.
    logic [1:0] count_reg;
    logic       en;
    logic       push;
    logic       pop;

    assign en      = (count_reg != 2'd2) || m_ready;
    assign s_ready = en;

    // Valid bits that travel alongside the data of each stage.
    logic valid_reg [0:PIPE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PIPE_DEPTH; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= s_valid;
            for (int i = 1; i < PIPE_DEPTH; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // First stage: 1 - w^2 in Q2.30, moved up by 16 bits so that its root lands in Q1.23.
    // w = -32768 gives exactly zero here, which is the zero-scale case.
    logic signed [31:0] w_sq;
    logic signed [31:0] one_minus;
    logic [RAD_W-1:0]   rad_reg;
    qta_quat_t          quat_reg;

    assign w_sq      = s_quat_w * s_quat_w;
    assign one_minus = 32'sd1073741824 - w_sq;

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg    <= {1'b0, one_minus[30:0], 16'b0};
            quat_reg.w <= s_quat_w;
            quat_reg.x <= s_quat_x;
            quat_reg.y <= s_quat_y;
            quat_reg.z <= s_quat_z;
        end
    end

    // Square root of the scale, with the quaternion delayed to meet it.
    logic [ROOT_W-1:0] scale;
    qta_quat_t         quat_dly;

    qta_isqrt u_isqrt (
        .aclk     (aclk),
        .en       (en),
        .radicand (rad_reg),
        .root     (scale)
    );

    qta_delay u_delay (
        .aclk (aclk),
        .en   (en),
        .din  (quat_reg),
        .dout (quat_dly)
    );

    // Angle and the three axis components are worked out in parallel.
    qta_result_t        res;
    logic signed [15:0] axis_x_q;
    logic signed [15:0] axis_y_q;
    logic signed [15:0] axis_z_q;
    logic [15:0]        angle_q;

    qta_cordic u_cordic (
        .aclk  (aclk),
        .en    (en),
        .w     (quat_dly.w),
        .s     (scale),
        .angle (angle_q)
    );

    qta_div u_div_x (
        .aclk (aclk),
        .en   (en),
        .c    (quat_dly.x),
        .s    (scale),
        .q    (axis_x_q)
    );

    qta_div u_div_y (
        .aclk (aclk),
        .en   (en),
        .c    (quat_dly.y),
        .s    (scale),
        .q    (axis_y_q)
    );

    qta_div u_div_z (
        .aclk (aclk),
        .en   (en),
        .c    (quat_dly.z),
        .s    (scale),
        .q    (axis_z_q)
    );

    assign res = {axis_x_q, axis_y_q, axis_z_q, angle_q};

    // Two-entry output queue. Its head drives the result channel; the second entry lets the
    // pipeline keep moving while a finished transaction waits to be taken.
    qta_result_t head_reg;
    qta_result_t tail_reg;
    logic [1:0]  count_next;

    assign push = en && valid_reg[PIPE_DEPTH-1];
    assign pop  = m_valid && m_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (push) begin
                if (count_reg == 2'd1) begin
                    head_reg <= res;
                end else begin
                    head_reg <= tail_reg;
                    tail_reg <= res;
                end
            end else begin
                head_reg <= tail_reg;
            end
        end else if (push) begin
            if (count_reg == 2'd0) begin
                head_reg <= res;
            end else begin
                tail_reg <= res;
            end
        end
    end

    assign m_valid     = (count_reg != 2'd0);
    assign m_axis_x    = head_reg.axis_x;
    assign m_axis_y    = head_reg.axis_y;
    assign m_axis_z    = head_reg.axis_z;
    assign m_angle_deg = head_reg.angle_deg;

`ifndef NO_ASSERTIONS
    // The queue never overflows: a full queue only takes a result while it drains.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(count_reg == 2'd2 && push && !pop))
        else $error("output queue overflow");

    // Input is refused only while the queue is full and stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (count_reg == 2'd2 && !m_ready))
        else $error("input refused without back-pressure");

    // The angle never passes a full turn.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_angle_deg <= 16'd46080))
        else $error("angle out of range");

    // A waiting result is held until the sink takes it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_angle_deg) && $stable(m_axis_x)))
        else $error("waiting result changed");
`endif

endmodule

// ===== rtl/core/qta_delay.sv =====
// Delay line that carries the quaternion alongside the square-root pipeline.
module qta_delay
    import qta_pkg::*;
(
    input  logic      aclk,
    input  logic      en,
    input  qta_quat_t din,
    output qta_quat_t dout
);

    qta_quat_t tap_reg [0:SQRT_STEPS-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= din;
            for (int i = 1; i < SQRT_STEPS; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[SQRT_STEPS-1];

endmodule

// ===== rtl/core/qta_isqrt.sv =====
// Pipelined digit-by-digit integer square root, one result bit per stage.
module qta_isqrt
    import qta_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [RAD_W-1:0]  radicand,
    output logic [ROOT_W-1:0] root
);

    localparam int REM_W = ROOT_W + 2;

    logic [REM_W-1:0]  rem_reg  [0:SQRT_STEPS-1];
    logic [ROOT_W-1:0] root_reg [0:SQRT_STEPS-1];
    logic [RAD_W-1:0]  rad_reg  [0:SQRT_STEPS-1];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        logic [REM_W-1:0]  rem_i;
        logic [ROOT_W-1:0] root_i;
        logic [RAD_W-1:0]  rad_i;
        logic [REM_W+1:0]  rs;
        logic [REM_W+1:0]  tr;
        logic              ge;

        if (k == 0) begin : g_first
            assign rem_i  = '0;
            assign root_i = '0;
            assign rad_i  = radicand;
        end else begin : g_rest
            assign rem_i  = rem_reg[k-1];
            assign root_i = root_reg[k-1];
            assign rad_i  = rad_reg[k-1];
        end

        assign rs = {rem_i, rad_i[RAD_W-1:RAD_W-2]};
        assign tr = {2'b00, root_i, 2'b01};
        assign ge = (rs >= tr);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? REM_W'(rs - tr) : rs[REM_W-1:0];
                root_reg[k] <= {root_i[ROOT_W-2:0], ge};
                rad_reg[k]  <= {rad_i[RAD_W-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[SQRT_STEPS-1];

endmodule

// ===== rtl/core/qta_cordic.sv =====
// Vectoring CORDIC pipeline that gives the half angle atan2(s, w) and the rounded full angle.
module qta_cordic
    import qta_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic signed [15:0] w,
    input  logic [ROOT_W-1:0]  s,
    output logic [15:0]        angle
);

    logic signed [XW-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [XW-1:0] y_reg [0:CORDIC_STEPS];
    angle_acc_t           z_reg [0:CORDIC_STEPS];
    logic [15:0]          angle_reg;

    logic signed [XW-1:0] w_ext;
    logic signed [XW-1:0] s_ext;

    assign w_ext = {{3{w[15]}}, w, 8'b0};
    assign s_ext = {3'b000, s};

    // A negative w starts from the vector turned by a quarter turn.
    always_ff @(posedge aclk) begin
        if (en) begin
            if (!w[15]) begin
                x_reg[0] <= w_ext;
                y_reg[0] <= s_ext;
                z_reg[0] <= '0;
            end else begin
                x_reg[0] <= s_ext;
                y_reg[0] <= XW'(0) - w_ext;
                z_reg[0] <= QUARTER_TURN_Q16;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        angle_acc_t           da;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign da = atan_deg(4'(i));

        always_ff @(posedge aclk) begin
            if (en) begin
                if (y_reg[i] > 0) begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + da;
                end else begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - da;
                end
            end
        end
    end

    angle_acc_t  z_clamp;
    logic [24:0] z_round;

    always_comb begin
        if (z_reg[CORDIC_STEPS] < 0) begin
            z_clamp = '0;
        end else if (z_reg[CORDIC_STEPS] > HALF_TURN_Q16) begin
            z_clamp = HALF_TURN_Q16;
        end else begin
            z_clamp = z_reg[CORDIC_STEPS];
        end
        z_round = {1'b0, z_clamp[23:0]} + 25'd128;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg <= z_round[23:8];
        end
    end

    assign angle = angle_reg;

endmodule

// ===== rtl/core/qta_div.sv =====
// Restoring divider pipeline for one axis component, rounded and saturated to Q1.15.
module qta_div
    import qta_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic signed [15:0] c,
    input  logic [ROOT_W-1:0]  s,
    output logic signed [15:0] q
);

    logic                neg_reg  [0:DIV_BITS];
    logic                zero_reg [0:DIV_BITS];
    logic                ovf_reg  [0:DIV_BITS];
    logic [ROOT_W-1:0]   s_reg    [0:DIV_BITS];
    logic [ROOT_W-1:0]   rem_reg  [0:DIV_BITS];
    logic [DIV_BITS-1:0] low_reg  [0:DIV_BITS];
    logic [DIV_BITS-1:0] quo_reg  [0:DIV_BITS];

    logic [15:0] mag;
    logic [38:0] num;

    // The numerator is mag * 2^23 + s / 2; the half divisor never reaches bit 23.
    assign mag = c[15] ? 16'(-c) : c;
    assign num = {mag, s[ROOT_W-1:1]};

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_reg[0]  <= c[15];
            zero_reg[0] <= (s == '0);
            ovf_reg[0]  <= ({2'b00, num[38:17]} >= s);
            s_reg[0]    <= s;
            rem_reg[0]  <= {2'b00, num[38:17]};
            low_reg[0]  <= num[16:0];
            quo_reg[0]  <= '0;
        end
    end

    for (genvar j = 0; j < DIV_BITS; j++) begin : g_bit
        logic [ROOT_W:0] rs;
        logic            ge;

        assign rs = {rem_reg[j], low_reg[j][DIV_BITS-1]};
        assign ge = (rs >= {1'b0, s_reg[j]});

        always_ff @(posedge aclk) begin
            if (en) begin
                neg_reg[j+1]  <= neg_reg[j];
                zero_reg[j+1] <= zero_reg[j];
                ovf_reg[j+1]  <= ovf_reg[j];
                s_reg[j+1]    <= s_reg[j];
                rem_reg[j+1]  <= ge ? ROOT_W'(rs - {1'b0, s_reg[j]}) : rs[ROOT_W-1:0];
                low_reg[j+1]  <= {low_reg[j][DIV_BITS-2:0], 1'b0};
                quo_reg[j+1]  <= {quo_reg[j][DIV_BITS-2:0], ge};
            end
        end
    end

    logic [DIV_BITS-1:0] quo;

    assign quo = quo_reg[DIV_BITS];

    always_comb begin
        if (zero_reg[DIV_BITS]) begin
            q = '0;
        end else if (neg_reg[DIV_BITS]) begin
            if (ovf_reg[DIV_BITS] || quo > 17'd32768) begin
                q = 16'sh8000;
            end else begin
                q = 16'(-quo[15:0]);
            end
        end else begin
            if (ovf_reg[DIV_BITS] || quo > 17'd32767) begin
                q = 16'sh7fff;
            end else begin
                q = quo[15:0];
            end
        end
    end

endmodule
